// ===== design/utf8_to_utf16_decoder_unit_defines.svh =====
// Assertion macros used by the checker file of the decoder.
`ifndef UTF8_TO_UTF16_DECODER_UNIT_DEFINES_SVH
`define UTF8_TO_UTF16_DECODER_UNIT_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define UTD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition implies a consequence on the following edge.
`define UTD_ASSERT_NEXT(lbl, cond, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/utd_pkg.sv =====
// Shared types and constants of the UTF-8 to UTF-16 decoder.
package utd_pkg;

    localparam int COUNT_WIDTH_DEF = 32;
    localparam int QUEUE_DEPTH     = 4;
    localparam int CP_WIDTH        = 21;

    localparam logic [30:0] CP_MAX_ACC   = 31'h10FFFF;
    localparam logic [20:0] CP_REPLACE   = 21'h00FFFD;
    localparam logic [20:0] CP_SUPP_BASE = 21'h010000;
    localparam logic [15:0] HI_SURR_BASE = 16'hD800;
    localparam logic [15:0] LO_SURR_BASE = 16'hDC00;

    typedef enum logic [1:0] {
        ST_UNIT    = 2'd0,
        ST_ILLEGAL = 2'd1,
        ST_TRUNC   = 2'd2
    } status_t;

    typedef struct packed {
        logic [CP_WIDTH-1:0] cp;
        status_t             status;
        logic                fin;
    } entry_t;

endpackage

// ===== design/utd_front.sv =====
// Front end: accepts bytes, tracks character state and emits decoded entries.
module utd_front #(
    parameter int COUNT_WIDTH = utd_pkg::COUNT_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             data_byte,
    input  logic                   frame_end,
    input  logic                   q_full,
    output logic                   push,
    output utd_pkg::entry_t        push_entry,
    output logic [COUNT_WIDTH-1:0] push_count
);

    logic [2:0]             bytes_left_reg, bytes_left_next;
    logic [30:0]            acc_reg, acc_next;
    logic [2:0]             char_len_reg, char_len_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic                   dropping_reg, dropping_next;

    logic                   accept;
    logic                   clear;
    logic [2:0]             addend;
    logic [COUNT_WIDTH:0]   count_sum;
    logic [COUNT_WIDTH-1:0] count_sat;
    logic [30:0]            acc_shift;
    logic [2:0]             bl_dec;

    assign in_ready  = !q_full;
    assign accept    = in_valid && !q_full;
    assign addend    = (bytes_left_reg == 3'd0) ? 3'd1 : char_len_reg;
    assign count_sum = {1'b0, count_reg} + (COUNT_WIDTH+1)'(addend);
    assign count_sat = count_sum[COUNT_WIDTH] ? '1 : count_sum[COUNT_WIDTH-1:0];
    assign acc_shift = {acc_reg[24:0], data_byte[5:0]};
    assign bl_dec    = bytes_left_reg - 3'd1;

    always_comb
    begin
        bytes_left_next   = bytes_left_reg;
        acc_next          = acc_reg;
        char_len_next     = char_len_reg;
        count_next        = count_reg;
        dropping_next     = dropping_reg;
        clear             = 1'b0;
        push              = 1'b0;
        push_entry.cp     = '0;
        push_entry.status = utd_pkg::ST_UNIT;
        push_entry.fin    = 1'b0;
        push_count        = count_reg;

        if (accept)
        begin
            if (dropping_reg)
            begin
                clear = frame_end;
            end
            else if (bytes_left_reg == 3'd0)
            begin
                priority if (!data_byte[7])
                begin
                    count_next     = count_sat;
                    push           = 1'b1;
                    push_entry.cp  = utd_pkg::CP_WIDTH'(data_byte);
                    push_entry.fin = frame_end;
                    push_count     = count_sat;
                    clear          = frame_end;
                end
                else if (!data_byte[6])
                begin
                    push              = 1'b1;
                    push_entry.status = utd_pkg::ST_ILLEGAL;
                    push_entry.fin    = 1'b1;
                    clear             = frame_end;
                    dropping_next     = 1'b1;
                end
                else
                begin
                    priority if (!data_byte[5])
                    begin
                        acc_next      = {26'd0, data_byte[4:0]};
                        char_len_next = 3'd2;
                    end
                    else if (!data_byte[4])
                    begin
                        acc_next      = {27'd0, data_byte[3:0]};
                        char_len_next = 3'd3;
                    end
                    else if (!data_byte[3])
                    begin
                        acc_next      = {28'd0, data_byte[2:0]};
                        char_len_next = 3'd4;
                    end
                    else if (!data_byte[2])
                    begin
                        acc_next      = {29'd0, data_byte[1:0]};
                        char_len_next = 3'd5;
                    end
                    else
                    begin
                        acc_next      = {30'd0, data_byte[0]};
                        char_len_next = 3'd6;
                    end
                    bytes_left_next = char_len_next - 3'd1;
                    if (frame_end)
                    begin
                        push              = 1'b1;
                        push_entry.status = utd_pkg::ST_TRUNC;
                        push_entry.fin    = 1'b1;
                        clear             = 1'b1;
                    end
                end
            end
            else
            begin
                acc_next        = acc_shift;
                bytes_left_next = bl_dec;
                if (bl_dec != 3'd0)
                begin
                    if (frame_end)
                    begin
                        push              = 1'b1;
                        push_entry.status = utd_pkg::ST_TRUNC;
                        push_entry.fin    = 1'b1;
                        clear             = 1'b1;
                    end
                end
                else
                begin
                    count_next     = count_sat;
                    push           = 1'b1;
                    push_entry.cp  = (acc_shift > utd_pkg::CP_MAX_ACC) ?
                                     utd_pkg::CP_REPLACE : acc_shift[20:0];
                    push_entry.fin = frame_end;
                    push_count     = count_sat;
                    acc_next       = '0;
                    char_len_next  = '0;
                    clear          = frame_end;
                end
            end
        end

        if (clear)
        begin
            bytes_left_next = '0;
            acc_next        = '0;
            char_len_next   = '0;
            count_next      = '0;
            dropping_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_left_reg <= '0;
            acc_reg        <= '0;
            char_len_reg   <= '0;
            count_reg      <= '0;
            dropping_reg   <= 1'b0;
        end
        else
        begin
            bytes_left_reg <= bytes_left_next;
            acc_reg        <= acc_next;
            char_len_reg   <= char_len_next;
            count_reg      <= count_next;
            dropping_reg   <= dropping_next;
        end
    end

endmodule

// ===== design/utd_fifo.sv =====
// Short register queue between the front end and the back end.
module utd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = utd_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             not_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push;
    logic             do_pop;

    assign full      = (cnt_reg == CNT_W'(DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign rd_data   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== design/utd_back.sv =====
// Back end: splits code points into UTF-16 units and drives the output register.
module utd_back #(
    parameter int COUNT_WIDTH = utd_pkg::COUNT_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_valid,
    input  utd_pkg::entry_t        q_entry,
    input  logic [COUNT_WIDTH-1:0] q_count,
    output logic                   q_pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [15:0]            code_unit,
    output logic [1:0]             status,
    output logic                   final_res,
    output logic [31:0]            bytes_done
);

    logic                   out_valid_reg, out_valid_next;
    logic [15:0]            unit_reg, unit_next;
    utd_pkg::status_t       status_reg, status_next;
    logic                   fin_reg, fin_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic                   pend_reg, pend_next;
    logic [15:0]            pend_unit_reg, pend_unit_next;
    logic                   pend_fin_reg, pend_fin_next;

    logic                   out_free;
    logic [20:0]            supp;
    logic [15:0]            hi_unit;
    logic [15:0]            lo_unit;

    assign out_free   = !out_valid_reg || out_ready;
    assign q_pop      = out_free && !pend_reg && q_valid;
    assign supp       = q_entry.cp - utd_pkg::CP_SUPP_BASE;
    assign hi_unit    = utd_pkg::HI_SURR_BASE + {6'd0, supp[19:10]};
    assign lo_unit    = utd_pkg::LO_SURR_BASE + {6'd0, supp[9:0]};

    assign out_valid  = out_valid_reg;
    assign code_unit  = unit_reg;
    assign status     = status_reg;
    assign final_res  = fin_reg;
    assign bytes_done = 32'(count_reg);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        unit_next      = unit_reg;
        status_next    = status_reg;
        fin_next       = fin_reg;
        count_next     = count_reg;
        pend_next      = pend_reg;
        pend_unit_next = pend_unit_reg;
        pend_fin_next  = pend_fin_reg;

        if (out_free)
        begin
            priority if (pend_reg)
            begin
                // send the low half of a surrogate pair
                out_valid_next = 1'b1;
                unit_next      = pend_unit_reg;
                status_next    = utd_pkg::ST_UNIT;
                fin_next       = pend_fin_reg;
                pend_next      = 1'b0;
            end
            else if (q_valid)
            begin
                out_valid_next = 1'b1;
                status_next    = q_entry.status;
                count_next     = q_count;
                if (q_entry.cp[20:16] != 5'd0)
                begin
                    unit_next      = hi_unit;
                    fin_next       = 1'b0;
                    pend_next      = 1'b1;
                    pend_unit_next = lo_unit;
                    pend_fin_next  = q_entry.fin;
                end
                else
                begin
                    unit_next = q_entry.cp[15:0];
                    fin_next  = q_entry.fin;
                end
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unit_reg      <= unit_next;
        status_reg    <= status_next;
        fin_reg       <= fin_next;
        count_reg     <= count_next;
        pend_unit_reg <= pend_unit_next;
        pend_fin_reg  <= pend_fin_next;
    end

endmodule

// ===== design/utf8_to_utf16_decoder_unit.sv =====
// Top level of the UTF-8 to UTF-16 decoder.
// Input channel: in_valid/in_ready carry one word per handshake, data_byte plus
// frame_end on the last byte of a frame. Output channel: out_valid/out_ready
// carry one UTF-16 code unit or error word with status, final_res and
// bytes_done (saturating count of bytes in finished characters of the frame).
// The front end decodes one byte per cycle while the queue has room and
// writes each finished character or error into a four-entry queue; the back
// end reads the queue and owns the output register.
// Throughput: one byte per cycle while the queue is not full. A character that
// needs a surrogate pair occupies the output register for both code units.
// A finished word is written into the queue at the edge that accepts its last
// byte; the back end loads it into the output register once that register is
// free and no low surrogate is pending.
// Reset clears the character state, byte count, drop flag, queue and output valid.
// When the receiver stalls, the output word holds, the queue fills, and
// in_ready drops once all four queue entries are taken.
module utf8_to_utf16_decoder_unit #(
    parameter int COUNT_WIDTH = utd_pkg::COUNT_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        frame_end,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] code_unit,
    output logic [1:0]  status,
    output logic        final_res,
    output logic [31:0] bytes_done
);

    localparam int Q_WIDTH = $bits(utd_pkg::entry_t) + COUNT_WIDTH;

    logic                   push;
    utd_pkg::entry_t        push_entry;
    logic [COUNT_WIDTH-1:0] push_count;
    logic                   q_full;
    logic                   q_valid;
    logic                   q_pop;
    logic [Q_WIDTH-1:0]     q_rd;
    utd_pkg::entry_t        q_entry;
    logic [COUNT_WIDTH-1:0] q_count;

    assign q_entry = utd_pkg::entry_t'(q_rd[Q_WIDTH-1:COUNT_WIDTH]);
    assign q_count = q_rd[COUNT_WIDTH-1:0];

    utd_front #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_byte  (data_byte),
        .frame_end  (frame_end),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry),
        .push_count (push_count)
    );

    utd_fifo #(
        .WIDTH(Q_WIDTH),
        .DEPTH(utd_pkg::QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wr_data   ({push_entry, push_count}),
        .pop       (q_pop),
        .rd_data   (q_rd),
        .full      (q_full),
        .not_empty (q_valid)
    );

    utd_back #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_entry    (q_entry),
        .q_count    (q_count),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .code_unit  (code_unit),
        .status     (status),
        .final_res  (final_res),
        .bytes_done (bytes_done)
    );

endmodule

// ===== design/utd_checker.sv =====
// Port-level assertions for the decoder, bound to the top level.
`include "utf8_to_utf16_decoder_unit_defines.svh"

module utd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] code_unit,
    input logic [1:0]  status,
    input logic        final_res,
    input logic [31:0] bytes_done
);

    `UTD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(code_unit) && $stable(status) && $stable(final_res) && $stable(bytes_done), "output word changed while stalled")
    `UTD_ASSERT(a_status_code, out_valid |-> (status == utd_pkg::ST_UNIT || status == utd_pkg::ST_ILLEGAL || status == utd_pkg::ST_TRUNC), "undefined status code")
    `UTD_ASSERT(a_err_final, out_valid && status != utd_pkg::ST_UNIT |-> final_res, "error word without final_res")
    `UTD_ASSERT(a_err_zero, out_valid && status != utd_pkg::ST_UNIT |-> code_unit == 16'h0000, "error word with nonzero code unit")

endmodule

bind utf8_to_utf16_decoder_unit utd_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .code_unit  (code_unit),
    .status     (status),
    .final_res  (final_res),
    .bytes_done (bytes_done)
);

// ===== tb/utf8_to_utf16_decoder_unit_tb.sv =====
// Self-checking testbench for the UTF-8 to UTF-16 decoder: random frames, backpressure, scoreboard.
module utf8_to_utf16_decoder_unit_tb;

    typedef struct packed {
        logic [7:0] b;
        logic       fe;
        logic       calm;
        logic       drain;
    } byte_item_t;

    typedef struct {
        logic [15:0]       unit;
        utd_pkg::status_t  st;
        logic              fin;
        logic [31:0]       done;
    } utf16_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte = 8'h00;
    logic        frame_end = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [15:0] code_unit;
    logic [1:0]  status;
    logic        final_res;
    logic [31:0] bytes_done;

    byte_item_t  byte_q[$];
    utf16_word_t exp_words[$];
    logic [7:0]  frame_bytes[$];

    logic [2:0]  cont_left = '0;
    logic [30:0] cp_acc = '0;
    logic [2:0]  char_len = '0;
    logic [31:0] frame_count = '0;
    logic        skipping = 1'b0;

    int n_errors = 0;
    int n_accepted = 0;
    int n_generated = 0;
    int tx_gap = 0;
    int rx_wait = 0;
    bit rx_calm = 1'b0;
    logic rx_hold = 1'b0;

    utf8_to_utf16_decoder_unit u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_byte  (data_byte),
        .frame_end  (frame_end),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .code_unit  (code_unit),
        .status     (status),
        .final_res  (final_res),
        .bytes_done (bytes_done)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        #400000;
        $display("utf8_to_utf16_decoder_unit regression: fail");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        n_errors++;
        if (n_errors <= 50)
            $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task automatic clear_frame_state();
        cont_left   = '0;
        cp_acc      = '0;
        char_len    = '0;
        frame_count = '0;
        skipping    = 1'b0;
    endtask

    task automatic bump_count(input logic [2:0] n);
        logic [32:0] sum;
        sum = {1'b0, frame_count} + n;
        frame_count = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    endtask

    task automatic push_word(input logic [15:0] unit, input utd_pkg::status_t st,
                             input logic fin);
        utf16_word_t w;
        w.unit = unit;
        w.st   = st;
        w.fin  = fin;
        w.done = frame_count;
        exp_words.push_back(w);
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic fe);
        logic [30:0] cp;
        logic [20:0] sup;
        if (skipping)
        begin
            if (fe)
                clear_frame_state();
        end
        else if (cont_left == 0)
        begin
            if (b < 8'h80)
            begin
                bump_count(3'd1);
                push_word({8'h00, b}, utd_pkg::ST_UNIT, fe);
                if (fe)
                    clear_frame_state();
            end
            else if (b < 8'hC0)
            begin
                push_word(16'h0000, utd_pkg::ST_ILLEGAL, 1'b1);
                if (fe)
                    clear_frame_state();
                else
                    skipping = 1'b1;
            end
            else
            begin
                if (b[7:5] == 3'b110)
                begin
                    cp_acc = {26'd0, b[4:0]};
                    char_len = 3'd2;
                end
                else if (b[7:4] == 4'b1110)
                begin
                    cp_acc = {27'd0, b[3:0]};
                    char_len = 3'd3;
                end
                else if (b[7:3] == 5'b11110)
                begin
                    cp_acc = {28'd0, b[2:0]};
                    char_len = 3'd4;
                end
                else if (b[7:2] == 6'b111110)
                begin
                    cp_acc = {29'd0, b[1:0]};
                    char_len = 3'd5;
                end
                else
                begin
                    cp_acc = {30'd0, b[0]};
                    char_len = 3'd6;
                end
                cont_left = char_len - 3'd1;
                if (fe)
                begin
                    push_word(16'h0000, utd_pkg::ST_TRUNC, 1'b1);
                    clear_frame_state();
                end
            end
        end
        else
        begin
            cp_acc = {cp_acc[24:0], b[5:0]};
            cont_left = cont_left - 3'd1;
            if (cont_left != 0)
            begin
                if (fe)
                begin
                    push_word(16'h0000, utd_pkg::ST_TRUNC, 1'b1);
                    clear_frame_state();
                end
            end
            else
            begin
                bump_count(char_len);
                cp = (cp_acc > utd_pkg::CP_MAX_ACC) ? {10'd0, utd_pkg::CP_REPLACE} : cp_acc;
                if (cp <= 31'h0000_FFFF)
                    push_word(cp[15:0], utd_pkg::ST_UNIT, fe);
                else
                begin
                    sup = cp[20:0] - utd_pkg::CP_SUPP_BASE;
                    push_word(utd_pkg::HI_SURR_BASE + {6'd0, sup[19:10]},
                              utd_pkg::ST_UNIT, 1'b0);
                    push_word(utd_pkg::LO_SURR_BASE + {6'd0, sup[9:0]},
                              utd_pkg::ST_UNIT, fe);
                end
                cp_acc = '0;
                char_len = '0;
                if (fe)
                    clear_frame_state();
            end
        end
    endtask

    task automatic push_item(input logic [7:0] b, input logic fe);
        byte_q.push_back('{b: b, fe: fe, calm: 1'b0, drain: 1'b0});
    endtask

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
            return 1;
        if (r < 55)
            return 2;
        if (r < 70)
            return 3;
        if (r < 88)
            return 4;
        if (r < 94)
            return 5;
        return 6;
    endfunction

    task automatic put_char(input int len, input int keep);
        logic [31:0] pay;
        logic [7:0]  lead;
        int k;
        pay = $urandom;
        case (len)
            1: lead = {1'b0, pay[6:0]};
            2: lead = {3'b110, pay[4:0]};
            3: lead = {4'b1110, pay[3:0]};
            4: lead = {5'b11110, pay[2:0]};
            5: lead = {6'b111110, pay[1:0]};
            default: lead = {6'b111111, pay[8], pay[0]};
        endcase
        frame_bytes.push_back(lead);
        for (k = 1; k < keep; k++)
        begin
            pay = $urandom;
            if ($urandom_range(0, 7) == 0)
                frame_bytes.push_back(pay[7:0]);
            else
                frame_bytes.push_back({2'b10, pay[5:0]});
        end
    endtask

    task automatic queue_frame(input bit calm, input bit drain);
        int nchar;
        int mode;
        int len;
        int i;
        logic [31:0] pay;
        frame_bytes.delete();
        nchar = $urandom_range(1, 6);
        mode = $urandom_range(0, 99);
        for (i = 0; i < nchar; i++)
        begin
            len = pick_len();
            put_char(len, len);
        end
        if (mode >= 90)
        begin
            pay = $urandom;
            frame_bytes.push_back({2'b10, pay[5:0]});
            n_generated += frame_bytes.size();
            len = $urandom_range(0, 3);
            for (i = 0; i < len; i++)
            begin
                pay = $urandom;
                frame_bytes.push_back(pay[7:0]);
            end
        end
        else
        begin
            if (mode >= 78)
            begin
                len = $urandom_range(2, 6);
                put_char(len, $urandom_range(1, len - 1));
            end
            n_generated += frame_bytes.size();
        end
        for (i = 0; i < frame_bytes.size(); i++)
            byte_q.push_back('{b: frame_bytes[i], fe: (i == frame_bytes.size() - 1),
                               calm: calm, drain: drain && (i == 0)});
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            data_byte <= 8'h00;
            frame_end <= 1'b0;
        end
        else
        begin : tx_side
            byte_item_t it;
            if (in_valid && in_ready)
            begin
                decode_byte(data_byte, frame_end);
                n_accepted++;
            end
            if (!in_valid || in_ready)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap--;
                    in_valid <= 1'b0;
                end
                else if (byte_q.size() != 0 && !(byte_q[0].drain && exp_words.size() != 0))
                begin
                    it = byte_q.pop_front();
                    in_valid  <= 1'b1;
                    data_byte <= it.b;
                    frame_end <= it.fe;
                    tx_gap = (it.calm || rx_hold) ? 0 : $urandom_range(0, 4);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin : rx_side
            utf16_word_t w;
            if (out_valid && out_ready)
            begin
                if (exp_words.size() == 0)
                    report_mismatch($sformatf("unexpected word unit %h status %0d",
                                              code_unit, status));
                else
                begin
                    w = exp_words.pop_front();
                    if (code_unit !== w.unit)
                        report_mismatch($sformatf("code_unit %h, want %h", code_unit, w.unit));
                    if (status !== w.st)
                        report_mismatch($sformatf("status %0d, want %0d", status, w.st));
                    if (final_res !== w.fin)
                        report_mismatch($sformatf("final_res %b, want %b", final_res, w.fin));
                    if (bytes_done !== w.done)
                        report_mismatch($sformatf("bytes_done %0d, want %0d",
                                                  bytes_done, w.done));
                end
                rx_wait = rx_calm ? 0 : $urandom_range(0, 4);
                if ($urandom_range(0, 149) == 0)
                    rx_calm = !rx_calm;
            end
            if (rx_hold)
                out_ready <= 1'b0;
            else if (rx_wait > 0)
            begin
                rx_wait--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin
        while (n_accepted < 300)
            @(posedge clk);
        rx_hold <= 1'b1;
        repeat (80) @(posedge clk);
        rx_hold <= 1'b0;
    end

    initial
    begin
        bit calm;
        int nframe;
        calm = 1'b0;
        nframe = 0;
        push_item(8'h00, 1'b0); push_item(8'h7F, 1'b1);
        push_item(8'hC2, 1'b0); push_item(8'hA9, 1'b0);
        push_item(8'hF0, 1'b0); push_item(8'h9F, 1'b0);
        push_item(8'h98, 1'b0); push_item(8'h80, 1'b1);
        push_item(8'hF4, 1'b0); push_item(8'h90, 1'b0);
        push_item(8'h80, 1'b0); push_item(8'h80, 1'b1);
        push_item(8'hFF, 1'b0); push_item(8'h80, 1'b0); push_item(8'h80, 1'b0);
        push_item(8'h80, 1'b0); push_item(8'h80, 1'b0); push_item(8'hBF, 1'b0);
        push_item(8'h80, 1'b0); push_item(8'h41, 1'b1);
        push_item(8'hBF, 1'b1);
        push_item(8'hE2, 1'b0); push_item(8'h82, 1'b1);
        push_item(8'hF8, 1'b1);
        while (n_generated < 1200)
        begin
            if ($urandom_range(0, 11) == 0)
                calm = !calm;
            queue_frame(calm, (nframe == 40) || ($urandom_range(0, 49) == 0));
            nframe++;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        while (byte_q.size() != 0 || in_valid)
            @(posedge clk);
        while (exp_words.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (n_errors == 0)
            $display("utf8_to_utf16_decoder_unit regression: pass");
        else
            $display("utf8_to_utf16_decoder_unit regression: fail");
        $finish;
    end
endmodule
